// ----- rtl/ccp_pkg.sv -----
`timescale 1ns / 1ps
// shared widths, status codes and result types for the circumcircle pipeline
// no dependencies

package ccp_pkg;

    // field and intermediate widths (raw fixed-point units)
    localparam int COORD_W = 32;               // coordinate and radius fields
    localparam int DIFF_W  = COORD_W + 1;      // point differences and sums
    localparam int PROD_W  = 2 * DIFF_W;       // product of two differences
    localparam int DET_W   = PROD_W + 1;       // determinant and dot term
    localparam int DLO_W   = 34;               // low slice of a determinant
    localparam int DHI_W   = DET_W - DLO_W;    // high slice, signed
    localparam int PL_W    = DIFF_W + DLO_W + 1;
    localparam int PH_W    = DIFF_W + DHI_W;
    localparam int WIDE_W  = 101;              // bisector numerators
    localparam int NUM_W   = WIDE_W + 1;       // divider dividend
    localparam int DEN_W   = DET_W + 1;        // divider divisor
    localparam int QB      = COORD_W + 1;      // quotient bits kept
    localparam int DIV_LAT = QB + 1;           // divider register stages
    localparam int D2_W    = 2 * COORD_W + 1;  // squared distance
    localparam int RT_W    = COORD_W + 1;      // root bits
    localparam int SQ_W    = D2_W + 2;         // root remainder and trial
    localparam int SQ_LAT  = RT_W + 1;         // root register stages

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_COLLINEAR = 2'd1,
        STATUS_SAT       = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic        [COORD_W-1:0] radius;
        t_status                   status;
    } t_result;

    typedef struct packed {
        logic signed [COORD_W-1:0] v;
        logic                      sat;
    } t_coord;

    // signed result of a rounded quotient magnitude, clamped to the field
    function automatic t_coord clamp_q(input logic [QB-1:0] q, input logic ovf,
                                       input logic neg);
        t_coord          r;
        logic [QB-1:0]   w_neg;
        logic            w_big;
        w_neg = QB'(0) - q;
        if (neg) begin
            w_big = ovf || (q[QB-1:COORD_W] != '0) ||
                    (q[COORD_W-1] && (q[COORD_W-2:0] != '0));
            r.v   = w_big ? {1'b1, {(COORD_W-1){1'b0}}} : w_neg[COORD_W-1:0];
        end else begin
            w_big = ovf || (q[QB-1:COORD_W-1] != '0);
            r.v   = w_big ? {1'b0, {(COORD_W-1){1'b1}}} : q[COORD_W-1:0];
        end
        r.sat = w_big;
        return r;
    endfunction

endpackage

// ----- rtl/ccp_in_if.sv -----
`timescale 1ns / 1ps
// input channel: three points per transfer, valid/ready handshake
// depends on ccp_pkg

interface ccp_in_if
    import ccp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;

    modport source (output valid, ax, ay, bx, by_coord, cx, cy, input ready);
    modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

// ----- rtl/ccp_out_if.sv -----
`timescale 1ns / 1ps
// output channel: center, radius and status per transfer, valid/ready handshake
// depends on ccp_pkg

interface ccp_out_if
    import ccp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic        [COORD_W-1:0] radius;
    t_status                   status;

    modport source (output valid, center_x, center_y, radius, status, input ready);
    modport sink   (input valid, center_x, center_y, radius, status, output ready);
endinterface

// ----- rtl/ccp_div.sv -----
`timescale 1ns / 1ps
// pipelined restoring divider: one quotient bit per stage, overflow check first
// depends on ccp_pkg

module ccp_div
    import ccp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_valid,
    output logic [QB-1:0]    o_q,
    output logic             o_ovf
);

    logic             r_v   [0:QB];
    logic [NUM_W-1:0] r_rem [0:QB];
    logic [DEN_W-1:0] r_den [0:QB];
    logic [QB-1:0]    r_q   [0:QB];
    logic             r_ovf [0:QB];

    // entry stage: quotient too large for the kept bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= i_num >= (NUM_W'(i_den) << QB);
        end
    end

    // one compare and subtract per stage, most significant bit first
    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic [NUM_W-1:0] w_sh;
        logic             w_ge;
        assign w_sh = NUM_W'(r_den[k-1]) << (QB - k);
        assign w_ge = r_rem[k-1] >= w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? r_rem[k-1] - w_sh : r_rem[k-1];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= {r_q[k-1][QB-2:0], w_ge};
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_q     = r_q[QB];
    assign o_ovf   = r_ovf[QB];

endmodule

// ----- rtl/ccp_sqrt.sv -----
`timescale 1ns / 1ps
// pipelined integer square root: one root bit per stage, remainder kept
// depends on ccp_pkg

module ccp_sqrt
    import ccp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [D2_W-1:0] i_d2,
    output logic            o_valid,
    output logic [RT_W-1:0] o_root,
    output logic [SQ_W-1:0] o_rem
);

    logic            r_v    [0:RT_W];
    logic [SQ_W-1:0] r_rem  [0:RT_W];
    logic [RT_W-1:0] r_root [0:RT_W];

    // entry stage: remainder starts at the full square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= SQ_W'(i_d2);
            r_root[0] <= '0;
        end
    end

    // try root + 2^b: the square grows by root*2^(b+1) + 2^(2b)
    for (genvar k = 1; k <= RT_W; k++) begin : g_stage
        logic [SQ_W-1:0] w_trial;
        logic            w_ge;
        assign w_trial = (SQ_W'(r_root[k-1]) << (RT_W - k + 1)) +
                         (SQ_W'(1) << (2 * (RT_W - k)));
        assign w_ge    = r_rem[k-1] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? r_rem[k-1] - w_trial : r_rem[k-1];
                r_root[k] <= r_root[k-1] | (RT_W'(w_ge) << (RT_W - k));
            end
        end
    end

    assign o_valid = r_v[RT_W];
    assign o_root  = r_root[RT_W];
    assign o_rem   = r_rem[RT_W];

endmodule

// ----- rtl/circle_through_three_points.sv -----
`timescale 1ns / 1ps
// circumcircle of three points: top level pipeline with output skid stage
// one item per cycle, unless a full skid register stalls the input
// the divider (34 stages) and the square root (34 stages) set the depth
// a stall holds the whole pipeline only once the output and skid registers are full
// reset (synchronous, active low) clears all valid bits; payload is not reset
// depends on ccp_pkg, ccp_in_if, ccp_out_if, ccp_div, ccp_sqrt

module circle_through_three_points
    import ccp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ccp_in_if.sink    i_in,
    ccp_out_if.source o_out
);

    typedef struct packed {
        logic                      negx;
        logic                      negy;
        logic                      col;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
    } t_dside;

    typedef struct packed {
        logic signed [COORD_W-1:0] mx;
        logic signed [COORD_W-1:0] my;
        logic                      sat;
        logic                      col;
    } t_sside;

    logic w_en;

    // stage 1: differences and sums
    logic                      r1_v;
    logic signed [DIFF_W-1:0]  r1_e1, r1_e2, r1_e3, r1_e4, r1_e5, r1_e6, r1_sx, r1_sy;
    logic signed [COORD_W-1:0] r1_ax, r1_ay;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_e1 <= DIFF_W'(i_in.by_coord) - DIFF_W'(i_in.ay);
            r1_e2 <= DIFF_W'(i_in.cx) - DIFF_W'(i_in.bx);
            r1_e3 <= DIFF_W'(i_in.bx) - DIFF_W'(i_in.ax);
            r1_e4 <= DIFF_W'(i_in.cy) - DIFF_W'(i_in.by_coord);
            r1_e5 <= DIFF_W'(i_in.cx) - DIFF_W'(i_in.ax);
            r1_e6 <= DIFF_W'(i_in.cy) - DIFF_W'(i_in.ay);
            r1_sx <= DIFF_W'(i_in.ax) + DIFF_W'(i_in.bx);
            r1_sy <= DIFF_W'(i_in.ay) + DIFF_W'(i_in.by_coord);
            r1_ax <= i_in.ax;
            r1_ay <= i_in.ay;
        end
    end

    // stage 2: products for determinant and dot term
    logic                      r2_v;
    logic signed [PROD_W-1:0]  r2_p1, r2_p2, r2_p3, r2_p4;
    logic signed [DIFF_W-1:0]  r2_e1, r2_e3, r2_sx, r2_sy;
    logic signed [COORD_W-1:0] r2_ax, r2_ay;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_p1 <= r1_e1 * r1_e2;
            r2_p2 <= r1_e3 * r1_e4;
            r2_p3 <= r1_e2 * r1_e5;
            r2_p4 <= r1_e4 * r1_e6;
            r2_e1 <= r1_e1;
            r2_e3 <= r1_e3;
            r2_sx <= r1_sx;
            r2_sy <= r1_sy;
            r2_ax <= r1_ax;
            r2_ay <= r1_ay;
        end
    end

    // stage 3: determinant and dot term
    logic                      r3_v;
    logic signed [DET_W-1:0]   r3_det, r3_n;
    logic signed [DIFF_W-1:0]  r3_e1, r3_e3, r3_sx, r3_sy;
    logic signed [COORD_W-1:0] r3_ax, r3_ay;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_det <= DET_W'(r2_p1) - DET_W'(r2_p2);
            r3_n   <= DET_W'(r2_p3) + DET_W'(r2_p4);
            r3_e1  <= r2_e1;
            r3_e3  <= r2_e3;
            r3_sx  <= r2_sx;
            r3_sy  <= r2_sy;
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
        end
    end

    // stage 4: partial products on split determinant and dot term
    logic signed [DLO_W:0]     w_dlo, w_nlo;
    logic signed [DHI_W-1:0]   w_dhi, w_nhi;
    logic                      r4_v, r4_col;
    logic signed [PL_W-1:0]    r4_sxdl, r4_e1nl, r4_sydl, r4_e3nl;
    logic signed [PH_W-1:0]    r4_sxdh, r4_e1nh, r4_sydh, r4_e3nh;
    logic signed [DET_W-1:0]   r4_det;
    logic signed [COORD_W-1:0] r4_ax, r4_ay;

    assign w_dlo = $signed({1'b0, r3_det[DLO_W-1:0]});
    assign w_nlo = $signed({1'b0, r3_n[DLO_W-1:0]});
    assign w_dhi = $signed(r3_det[DET_W-1:DLO_W]);
    assign w_nhi = $signed(r3_n[DET_W-1:DLO_W]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sxdl <= r3_sx * w_dlo;
            r4_sxdh <= r3_sx * w_dhi;
            r4_e1nl <= r3_e1 * w_nlo;
            r4_e1nh <= r3_e1 * w_nhi;
            r4_sydl <= r3_sy * w_dlo;
            r4_sydh <= r3_sy * w_dhi;
            r4_e3nl <= r3_e3 * w_nlo;
            r4_e3nh <= r3_e3 * w_nhi;
            r4_col  <= r3_det == '0;
            r4_det  <= r3_det;
            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;
        end
    end

    // stage 5: reassemble the four wide products
    logic                      r5_v, r5_col;
    logic signed [WIDE_W-1:0]  r5_a, r5_b, r5_c, r5_d;
    logic signed [DET_W-1:0]   r5_det;
    logic signed [COORD_W-1:0] r5_ax, r5_ay;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_a   <= (WIDE_W'(r4_sxdh) <<< DLO_W) + WIDE_W'(r4_sxdl);
            r5_b   <= (WIDE_W'(r4_e1nh) <<< DLO_W) + WIDE_W'(r4_e1nl);
            r5_c   <= (WIDE_W'(r4_sydh) <<< DLO_W) + WIDE_W'(r4_sydl);
            r5_d   <= (WIDE_W'(r4_e3nh) <<< DLO_W) + WIDE_W'(r4_e3nl);
            r5_col <= r4_col;
            r5_det <= r4_det;
            r5_ax  <= r4_ax;
            r5_ay  <= r4_ay;
        end
    end

    // stage 6: bisector intersection numerators
    logic                      r6_v, r6_col;
    logic signed [WIDE_W-1:0]  r6_px, r6_py;
    logic signed [DET_W-1:0]   r6_det;
    logic signed [COORD_W-1:0] r6_ax, r6_ay;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_px  <= r5_a + r5_b;
            r6_py  <= r5_c - r5_d;
            r6_col <= r5_col;
            r6_det <= r5_det;
            r6_ax  <= r5_ax;
            r6_ay  <= r5_ay;
        end
    end

    // stage 7: rounding numerators |p| + |d| over divisor 2|d|
    logic [WIDE_W-1:0] w_pxa, w_pya;
    logic [DET_W-1:0]  w_da;
    t_dside            w_dside;
    logic              r7_v;
    logic [NUM_W-1:0]  r7_numx, r7_numy;
    logic [DEN_W-1:0]  r7_den;
    t_dside            r7_dside;

    assign w_pxa  = r6_px[WIDE_W-1] ? WIDE_W'(-r6_px) : WIDE_W'(r6_px);
    assign w_pya  = r6_py[WIDE_W-1] ? WIDE_W'(-r6_py) : WIDE_W'(r6_py);
    assign w_da   = r6_det[DET_W-1] ? DET_W'(-r6_det) : DET_W'(r6_det);

    assign w_dside.negx = r6_px[WIDE_W-1] ^ r6_det[DET_W-1];
    assign w_dside.negy = r6_py[WIDE_W-1] ^ r6_det[DET_W-1];
    assign w_dside.col  = r6_col;
    assign w_dside.ax   = r6_ax;
    assign w_dside.ay   = r6_ay;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_numx  <= NUM_W'(w_pxa) + NUM_W'(w_da);
            r7_numy  <= NUM_W'(w_pya) + NUM_W'(w_da);
            r7_den   <= {w_da, 1'b0};
            r7_dside <= w_dside;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    logic          w_qx_v, w_qy_v, w_ovfx, w_ovfy;
    logic [QB-1:0] w_qx, w_qy;

    ccp_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r7_v),
        .i_num   (r7_numx),
        .i_den   (r7_den),
        .o_valid (w_qx_v),
        .o_q     (w_qx),
        .o_ovf   (w_ovfx)
    );

    ccp_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r7_v),
        .i_num   (r7_numy),
        .i_den   (r7_den),
        .o_valid (w_qy_v),
        .o_q     (w_qy),
        .o_ovf   (w_ovfy)
    );

    // side data alongside the dividers
    t_dside r_dline [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dline[0] <= r7_dside;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dline[k] <= r_dline[k-1];
            end
        end
    end

    // stage A: clamp center coordinates
    t_coord                    w_cx, w_cy;
    logic                      rA_v, rA_sat, rA_col;
    logic signed [COORD_W-1:0] rA_mx, rA_my, rA_ax, rA_ay;

    assign w_cx = clamp_q(w_qx, w_ovfx, r_dline[DIV_LAT-1].negx);
    assign w_cy = clamp_q(w_qy, w_ovfy, r_dline[DIV_LAT-1].negy);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rA_mx  <= w_cx.v;
            rA_my  <= w_cy.v;
            rA_sat <= w_cx.sat | w_cy.sat;
            rA_col <= r_dline[DIV_LAT-1].col;
            rA_ax  <= r_dline[DIV_LAT-1].ax;
            rA_ay  <= r_dline[DIV_LAT-1].ay;
        end
    end

    // stage B: distance components from center to first point
    logic signed [DIFF_W-1:0]  w_dx, w_dy;
    logic        [DIFF_W-1:0]  w_dxa, w_dya;
    logic                      rB_v, rB_sat, rB_col;
    logic        [COORD_W-1:0] rB_dx, rB_dy;
    logic signed [COORD_W-1:0] rB_mx, rB_my;

    assign w_dx  = DIFF_W'(rA_mx) - DIFF_W'(rA_ax);
    assign w_dy  = DIFF_W'(rA_my) - DIFF_W'(rA_ay);
    assign w_dxa = w_dx[DIFF_W-1] ? DIFF_W'(-w_dx) : DIFF_W'(w_dx);
    assign w_dya = w_dy[DIFF_W-1] ? DIFF_W'(-w_dy) : DIFF_W'(w_dy);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rB_dx  <= w_dxa[COORD_W-1:0];
            rB_dy  <= w_dya[COORD_W-1:0];
            rB_mx  <= rA_mx;
            rB_my  <= rA_my;
            rB_sat <= rA_sat;
            rB_col <= rA_col;
        end
    end

    // stage C: squares
    logic                        rC_v;
    logic [2*COORD_W-1:0]        rC_sx, rC_sy;
    t_sside                      rC_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rC_sx       <= rB_dx * rB_dx;
            rC_sy       <= rB_dy * rB_dy;
            rC_side.mx  <= rB_mx;
            rC_side.my  <= rB_my;
            rC_side.sat <= rB_sat;
            rC_side.col <= rB_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_v <= 1'b0;
            rB_v <= 1'b0;
            rC_v <= 1'b0;
        end else if (w_en) begin
            rA_v <= w_qx_v & w_qy_v;
            rB_v <= rA_v;
            rC_v <= rB_v;
        end
    end

    logic [D2_W-1:0] w_d2;
    logic            w_rt_v;
    logic [RT_W-1:0] w_root;
    logic [SQ_W-1:0] w_rem;

    assign w_d2 = D2_W'(rC_sx) + D2_W'(rC_sy);

    ccp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (rC_v),
        .i_d2    (w_d2),
        .o_valid (w_rt_v),
        .o_root  (w_root),
        .o_rem   (w_rem)
    );

    // side data alongside the square root
    t_sside r_sline [0:SQ_LAT-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sline[0] <= rC_side;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_sline[k] <= r_sline[k-1];
            end
        end
    end

    // final stage: round root, clamp radius, pick status
    logic    [RT_W:0] w_rr;
    logic             w_rsat;
    t_sside           w_ss;
    t_result          w_res;
    logic             r_fv;
    t_result          r_fin;

    assign w_ss   = r_sline[SQ_LAT-1];
    assign w_rr   = {1'b0, w_root} + (RT_W + 1)'(w_rem > SQ_W'(w_root));
    assign w_rsat = w_rr[RT_W:COORD_W] != '0;

    always_comb begin
        w_res.center_x = w_ss.mx;
        w_res.center_y = w_ss.my;
        w_res.radius   = w_rsat ? '1 : w_rr[COORD_W-1:0];
        w_res.status   = (w_ss.sat || w_rsat) ? STATUS_SAT : STATUS_OK;
        if (w_ss.col) begin
            w_res.center_x = '0;
            w_res.center_y = '0;
            w_res.radius   = '0;
            w_res.status   = STATUS_COLLINEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_en) begin
            r_fv <= w_rt_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin <= w_res;
        end
    end

    // output register with skid entry; the pipeline halts only when the skid is full
    logic    r_ov, r_sv, w_take;
    t_result r_out, r_skid;

    assign w_en   = !r_sv;
    assign w_take = o_out.ready || !r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_take) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= r_fv;
            end
        end else if (r_fv) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= r_sv ? r_skid : r_fin;
        end else if (w_en) begin
            r_skid <= r_fin;
        end
    end

    assign i_in.ready     = w_en;
    assign o_out.valid    = r_ov;
    assign o_out.center_x = r_out.center_x;
    assign o_out.center_y = r_out.center_y;
    assign o_out.radius   = r_out.radius;
    assign o_out.status   = r_out.status;

endmodule

// ----- tb/sv/circle_through_three_points_tb.sv -----
`timescale 1ns / 1ps
// testbench for the circumcircle pipeline: directed and random point triples,
// each result checked against a predicted center, radius and status
// depends on ccp_pkg, ccp_in_if, ccp_out_if and circle_through_three_points

module circle_through_three_points_tb;
    import ccp_pkg::*;

    localparam int PIPE_LAT = 80;
    localparam logic signed [31:0] MAX_C = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_C = 32'sh8000_0000;

    logic i_clk;
    logic i_rst_n;

    ccp_in_if  in_ch ();
    ccp_out_if out_ch ();

    circle_through_three_points i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_result circle_q[$];
    int      fail_cnt  = 0;
    bit      idle_on   = 1'b1;
    int      hold_left = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5ms;
        $display("circle_through_three_points_tb NOT OK");
        $finish;
    end

    // rounded quotient p / den, ties away from zero, clamped to 32 bits
    function automatic logic signed [63:0] round_quot(input logic signed [127:0] p,
                                                      input logic signed [127:0] den,
                                                      inout logic sat);
        logic [127:0] pm;
        logic [127:0] dm;
        logic [127:0] q;
        logic         neg;
        pm  = (p < 0) ? -p : p;
        dm  = (den < 0) ? -den : den;
        q   = (2 * pm + dm) / (2 * dm);
        neg = ((p < 0) != (den < 0)) && (q != 0);
        if (neg) begin
            if (q > 128'h8000_0000) begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return -$signed(64'(q));
        end
        if (q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        return $signed(64'(q));
    endfunction

    // circumcenter and radius of one point triple
    function automatic t_result predict_circle(input logic signed [31:0] ax, ay, bx, by,
                                               cx, cy);
        logic signed [127:0] xa, ya, xb, yb, xc, yc;
        logic signed [127:0] det, n, px, py;
        logic signed [63:0]  mx, my, ddx, ddy;
        logic [127:0]        d2, r, t;
        logic                sat;
        t_result             res;
        xa = ax; ya = ay; xb = bx; yb = by; xc = cx; yc = cy;
        sat = 1'b0;
        det = (yb - ya) * (xc - xb) - (xb - xa) * (yc - yb);
        if (det == 0) begin
            res.center_x = '0;
            res.center_y = '0;
            res.radius   = '0;
            res.status   = STATUS_COLLINEAR;
            return res;
        end
        n  = (xc - xb) * (xc - xa) + (yc - yb) * (yc - ya);
        px = (xa + xb) * det + (yb - ya) * n;
        py = (ya + yb) * det - (xb - xa) * n;
        mx = round_quot(px, 2 * det, sat);
        my = round_quot(py, 2 * det, sat);
        // radius from the clamped center, rounded square root
        ddx = mx - 64'(xa);
        ddy = my - 64'(ya);
        if (ddx < 0) ddx = -ddx;
        if (ddy < 0) ddy = -ddy;
        d2 = 128'(ddx) * 128'(ddx) + 128'(ddy) * 128'(ddy);
        r  = '0;
        for (int b = 33; b >= 0; b--) begin
            t = r + (128'(1) << b);
            if (t * t <= d2) r = t;
        end
        if (d2 > r * r + r) r = r + 1;
        if (r > 128'hFFFF_FFFF) begin
            r   = 128'hFFFF_FFFF;
            sat = 1'b1;
        end
        res.center_x = mx[31:0];
        res.center_y = my[31:0];
        res.radius   = r[31:0];
        res.status   = sat ? STATUS_SAT : STATUS_OK;
        return res;
    endfunction

    // send one triple, with an optional idle burst before it
    task automatic send_points(input logic signed [31:0] ax, ay, bx, by, cx, cy);
        int gap;
        if (idle_on && ($urandom_range(0, 5) == 0)) begin
            gap = $urandom_range(1, 11);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.ax       <= ax;
        in_ch.ay       <= ay;
        in_ch.bx       <= bx;
        in_ch.by_coord <= by;
        in_ch.cx       <= cx;
        in_ch.cy       <= cy;
        do @(posedge i_clk); while (!in_ch.ready);
        circle_q.push_back(predict_circle(ax, ay, bx, by, cx, cy));
    endtask

    function automatic logic signed [31:0] rnd_full();
        case ($urandom_range(0, 4))
            0: return MAX_C;
            1: return MIN_C;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic signed [31:0] rnd_near(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // extremes, collinear, coincident and saturating triples
    task automatic test_directed();
        send_points(0, 0, 32'sh10000, 0, 0, 32'sh10000);
        send_points(0, 0, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh20000);
        send_points(5, 5, 5, 5, 5, 5);
        send_points(1, 2, 1, 2, 7, 9);
        send_points(MIN_C, MIN_C, MAX_C, MIN_C, MIN_C, MAX_C);
        send_points(MAX_C, MAX_C, MIN_C, MAX_C, MAX_C, MIN_C);
        send_points(MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MAX_C);
        send_points(MAX_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C);
        send_points(MIN_C, 0, MAX_C, 0, 0, MAX_C);
        send_points(0, 0, 1, 0, 0, 1);
        send_points(0, 0, 1, 0, 2, 1);
        send_points(0, 0, 32'sh10000, 1, 32'sh20000, 0);
        send_points(MAX_C, MAX_C, MAX_C - 1, MAX_C, MAX_C, MAX_C - 1);
        send_points(MIN_C, MIN_C, MIN_C + 1, MIN_C, MIN_C, MIN_C + 1);
        send_points(-3, 4, 3, 4, 0, -5);
        send_points(-1, -1, 0, 0, 1, 1);
        send_points(32'sh0001_8000, -32'sh0002_4000, 32'sh0003_0000, 32'sh0000_8000,
                    -32'sh0001_0000, 32'sh0004_0000);
    endtask

    // random triples: mostly moderate spans, some full range
    task automatic test_random(input int count);
        int span;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                send_points(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                            rnd_full());
            end else begin
                span = 1 << $urandom_range(2, 29);
                send_points(rnd_near(span), rnd_near(span), rnd_near(span),
                            rnd_near(span), rnd_near(span), rnd_near(span));
            end
        end
    endtask

    // receiver holds off long enough for the pipeline to fill and stall its input
    task automatic test_backpressure();
        hold_left = 300;
        test_random(120);
    endtask

    // result ready with random stalls and the long hold
    initial begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && ($urandom_range(0, 6) == 0)) begin
                stall_left = $urandom_range(0, 10);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (circle_q.size() == 0) begin
                $error("result transfer with no prediction pending");
                fail_cnt++;
            end else begin
                want = circle_q.pop_front();
                if (out_ch.center_x !== want.center_x) begin
                    $error("center_x expected %0d actual %0d", want.center_x,
                           out_ch.center_x);
                    fail_cnt++;
                end
                if (out_ch.center_y !== want.center_y) begin
                    $error("center_y expected %0d actual %0d", want.center_y,
                           out_ch.center_y);
                    fail_cnt++;
                end
                if (out_ch.radius !== want.radius) begin
                    $error("radius expected %0d actual %0d", want.radius, out_ch.radius);
                    fail_cnt++;
                end
                if (out_ch.status !== want.status) begin
                    $error("status expected %s actual %0d", want.status.name(),
                           out_ch.status);
                    fail_cnt++;
                end
            end
        end
    end

    // sequence of tests
    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.ax       = '0;
        in_ch.ay       = '0;
        in_ch.bx       = '0;
        in_ch.by_coord = '0;
        in_ch.cx       = '0;
        in_ch.cy       = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(320);
        test_backpressure();
        idle_on = 1'b0;
        test_random(200);
        in_ch.valid <= 1'b0;
        while (circle_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 20) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("circle_through_three_points_tb OK");
        end else begin
            $display("circle_through_three_points_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ccp_pkg.sv
rtl/ccp_in_if.sv
rtl/ccp_out_if.sv
rtl/ccp_div.sv
rtl/ccp_sqrt.sv
rtl/circle_through_three_points.sv
tb/sv/circle_through_three_points_tb.sv
